// ----- sv/blcq_pkg.sv -----
// shared types and constants for the block-linked character queues
package blcq_pkg;

   localparam int QID_W    = 4;
   localparam int CHAR_W   = 8;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 11;
   localparam int BSIZE_W  = 6;

   localparam logic [BSIZE_W-1:0] BSIZE_RESET = 6'd32;

   localparam logic REQ_PUT = 1'b0;
   localparam logic REQ_GET = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NO_BLOCK = 2'd2;

   localparam int CMDQ_DEPTH = 2;
   localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

   typedef enum logic [1:0] {
      CMD_PUT        = 2'd0,
      CMD_GET        = 2'd1,
      CMD_PUT_ABSENT = 2'd2,
      CMD_GET_ABSENT = 2'd3
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type        kind;
      logic [QID_W-1:0]    queue_id;
      logic [CHAR_W-1:0]   char_val;
   } cmd_type;

endpackage

// ----- sv/blcq_front.sv -----
// request intake: classifies each transaction and holds it in a short command queue
module blcq_front #(
   parameter int NUM_QUEUES = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_type,
   input  logic [blcq_pkg::QID_W-1:0]  req_queue_id,
   input  logic [blcq_pkg::CHAR_W-1:0] req_char_in,
   output logic                        cmd_valid,
   input  logic                        cmd_pop,
   output blcq_pkg::cmd_type           cmd
);

   blcq_pkg::cmd_type                     slot_ff [blcq_pkg::CMDQ_DEPTH];
   logic [blcq_pkg::CMDQ_PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [blcq_pkg::CMDQ_PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [blcq_pkg::CMDQ_CNT_W-1:0]       count_ff, count_in;
   logic                                  push;
   logic                                  absent;
   blcq_pkg::cmd_type                     new_cmd;

   // queues beyond the configured count do not exist
   assign absent = int'(req_queue_id) >= NUM_QUEUES;

   always_comb begin
      new_cmd.queue_id = req_queue_id;
      new_cmd.char_val = req_char_in;
      if (req_type == blcq_pkg::REQ_GET) begin
         new_cmd.kind = absent ? blcq_pkg::CMD_GET_ABSENT : blcq_pkg::CMD_GET;
      end else begin
         new_cmd.kind = absent ? blcq_pkg::CMD_PUT_ABSENT : blcq_pkg::CMD_PUT;
      end
   end

   assign req_ready = count_ff != blcq_pkg::CMDQ_CNT_W'(blcq_pkg::CMDQ_DEPTH);
   assign push      = req_valid && req_ready;
   assign cmd_valid = count_ff != '0;
   assign cmd       = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == blcq_pkg::CMDQ_PTR_W'(blcq_pkg::CMDQ_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + blcq_pkg::CMDQ_PTR_W'(1);
      end
      if (cmd_pop) begin
         rd_ptr_in = (rd_ptr_ff == blcq_pkg::CMDQ_PTR_W'(blcq_pkg::CMDQ_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + blcq_pkg::CMDQ_PTR_W'(1);
      end
      if (push && !cmd_pop) begin
         count_in = count_ff + blcq_pkg::CMDQ_CNT_W'(1);
      end else if (!push && cmd_pop) begin
         count_in = count_ff - blcq_pkg::CMDQ_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

// ----- sv/blcq_back.sv -----
// execution engine: queue tables, block pool memories and the free list
module blcq_back #(
   parameter int NUM_BLOCKS  = 32,
   parameter int BLOCK_BYTES = 32,
   parameter int NUM_QUEUES  = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cmd_valid,
   output logic                          cmd_pop,
   input  blcq_pkg::cmd_type             cmd,
   input  logic [blcq_pkg::BSIZE_W-1:0]  block_size,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [blcq_pkg::CHAR_W-1:0]   rsp_char_out,
   output logic [blcq_pkg::STATUS_W-1:0] rsp_status,
   output logic [blcq_pkg::COUNT_W-1:0]  rsp_queue_count
);

   localparam int QMAX = 2 ** blcq_pkg::QID_W;
   localparam int QN   = (NUM_QUEUES < QMAX) ? NUM_QUEUES : QMAX;
   localparam int QIW  = (QN > 1) ? $clog2(QN) : 1;
   localparam int BIW  = $clog2(NUM_BLOCKS + 1);
   localparam int BAW  = $clog2(NUM_BLOCKS);
   localparam int OW   = $clog2(BLOCK_BYTES + 1);
   localparam int AW   = $clog2(NUM_BLOCKS * BLOCK_BYTES);
   localparam int FW   = $clog2(NUM_BLOCKS * BLOCK_BYTES + 1);
   localparam logic [BIW-1:0] NULL_BLK = BIW'(NUM_BLOCKS);

   typedef enum logic [3:0] {
      ST_ISSUE    = 4'b0001,
      ST_GET_ADDR = 4'b0010,
      ST_GET_DONE = 4'b0100,
      ST_PUT_DONE = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // per-queue tables
   logic [BIW-1:0] head_ff [QN];
   logic [BIW-1:0] tail_ff [QN];
   logic [FW-1:0]  fill_ff [QN];

   // block pool memories
   logic [BIW-1:0]                link_mem  [NUM_BLOCKS];
   logic [OW-1:0]                 start_mem [NUM_BLOCKS];
   logic [OW-1:0]                 end_mem   [NUM_BLOCKS];
   logic [blcq_pkg::CHAR_W-1:0]   byte_mem  [NUM_BLOCKS * BLOCK_BYTES];

   logic [BIW-1:0]                link_rd_ff;
   logic [OW-1:0]                 start_rd_ff;
   logic [OW-1:0]                 end_rd_ff;
   logic [blcq_pkg::CHAR_W-1:0]   byte_rd_ff;

   logic [BIW-1:0]                free_head_ff, free_head_in;
   logic [BIW-1:0]                fresh_cnt_ff, fresh_cnt_in;
   blcq_pkg::cmd_type             cmd_ff, cmd_in;
   logic [BIW-1:0]                head_q_ff, head_q_in;
   logic [BIW-1:0]                tail_q_ff, tail_q_in;
   logic [FW-1:0]                 fill_q_ff, fill_q_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [blcq_pkg::CHAR_W-1:0]   rsp_char_ff, rsp_char_in;
   logic [blcq_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [blcq_pkg::COUNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic                          rsp_load;

   logic [QIW-1:0]                q_sel, q_cur;
   logic [BIW-1:0]                h_sel, t_sel;
   logic [FW-1:0]                 fill_sel;
   logic                          slot_free;
   logic [OW-1:0]                 eff;
   logic [OW-1:0]                 s_next;
   logic                          need;
   logic                          fresh;

   logic                          head_we, tail_we, fill_we;
   logic [BIW-1:0]                head_wdata, tail_wdata;
   logic [FW-1:0]                 fill_wdata;

   logic                          link_we, start_we, end_we, byte_we;
   logic [BAW-1:0]                link_waddr, start_waddr, end_waddr;
   logic [BIW-1:0]                link_wdata;
   logic [OW-1:0]                 start_wdata, end_wdata;
   logic [AW-1:0]                 byte_waddr;
   logic [blcq_pkg::CHAR_W-1:0]   byte_wdata;
   logic [BAW-1:0]                link_raddr, start_raddr, end_raddr;
   logic [AW-1:0]                 byte_raddr;

   assign q_sel     = cmd.queue_id[QIW-1:0];
   assign q_cur     = cmd_ff.queue_id[QIW-1:0];
   assign h_sel     = head_ff[q_sel];
   assign t_sel     = tail_ff[q_sel];
   assign fill_sel  = fill_ff[q_sel];
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // block size zero acts as one, anything above the block capacity saturates
   always_comb begin
      if (block_size == '0) begin
         eff = OW'(1);
      end else if (int'(block_size) > BLOCK_BYTES) begin
         eff = OW'(BLOCK_BYTES);
      end else begin
         eff = OW'(block_size);
      end
   end

   assign s_next = start_rd_ff + OW'(1);
   assign need   = (tail_q_ff == NULL_BLK) || (end_rd_ff >= eff);
   // blocks below the fresh count were never handed out and still chain downward
   assign fresh  = free_head_ff < fresh_cnt_ff;

   // link, start and end read addresses are set up while the command is issued
   assign start_raddr = h_sel[BAW-1:0];
   assign end_raddr   = (cmd.kind == blcq_pkg::CMD_GET) ? h_sel[BAW-1:0] : t_sel[BAW-1:0];
   assign link_raddr  = (cmd.kind == blcq_pkg::CMD_GET) ? h_sel[BAW-1:0] :
                        free_head_ff[BAW-1:0];
   assign byte_raddr  = AW'(head_q_ff[BAW-1:0]) * AW'(BLOCK_BYTES) + AW'(start_rd_ff);

   always_comb begin
      state_in      = state_ff;
      free_head_in  = free_head_ff;
      fresh_cnt_in  = fresh_cnt_ff;
      cmd_in        = cmd_ff;
      head_q_in     = head_q_ff;
      tail_q_in     = tail_q_ff;
      fill_q_in     = fill_q_ff;
      cmd_pop       = 1'b0;
      rsp_load      = 1'b0;
      rsp_char_in   = '0;
      rsp_status_in = blcq_pkg::STATUS_OK;
      rsp_count_in  = '0;
      head_we       = 1'b0;
      tail_we       = 1'b0;
      fill_we       = 1'b0;
      head_wdata    = head_q_ff;
      tail_wdata    = tail_q_ff;
      fill_wdata    = fill_q_ff;
      link_we       = 1'b0;
      link_waddr    = head_q_ff[BAW-1:0];
      link_wdata    = free_head_ff;
      start_we      = 1'b0;
      start_waddr   = head_q_ff[BAW-1:0];
      start_wdata   = s_next;
      end_we        = 1'b0;
      end_waddr     = tail_q_ff[BAW-1:0];
      end_wdata     = end_rd_ff + OW'(1);
      byte_we       = 1'b0;
      byte_waddr    = AW'(tail_q_ff[BAW-1:0]) * AW'(BLOCK_BYTES) + AW'(end_rd_ff);
      byte_wdata    = cmd_ff.char_val;

      case (state_ff)
         ST_ISSUE: begin
            // a transaction starts only when its result has a free slot
            if (cmd_valid && slot_free) begin
               cmd_pop   = 1'b1;
               cmd_in    = cmd;
               head_q_in = h_sel;
               tail_q_in = t_sel;
               fill_q_in = fill_sel;
               case (cmd.kind)
                  blcq_pkg::CMD_GET: begin
                     if (fill_sel == '0) begin
                        rsp_load      = 1'b1;
                        rsp_status_in = blcq_pkg::STATUS_EMPTY;
                     end else begin
                        state_in = ST_GET_ADDR;
                     end
                  end
                  blcq_pkg::CMD_PUT: begin
                     state_in = ST_PUT_DONE;
                  end
                  blcq_pkg::CMD_GET_ABSENT: begin
                     rsp_load      = 1'b1;
                     rsp_status_in = blcq_pkg::STATUS_EMPTY;
                  end
                  default: begin
                     rsp_load      = 1'b1;
                     rsp_status_in = blcq_pkg::STATUS_NO_BLOCK;
                  end
               endcase
            end
         end
         ST_GET_ADDR: begin
            start_we   = 1'b1;
            fill_q_in  = fill_q_ff - FW'(1);
            fill_we    = 1'b1;
            fill_wdata = fill_q_ff - FW'(1);
            if (s_next >= end_rd_ff) begin
               // head block drained: push it on the free list
               link_we      = 1'b1;
               free_head_in = head_q_ff;
               head_we      = 1'b1;
               if (head_q_ff == tail_q_ff) begin
                  head_wdata = NULL_BLK;
                  tail_we    = 1'b1;
                  tail_wdata = NULL_BLK;
               end else begin
                  head_wdata = link_rd_ff;
               end
            end
            state_in = ST_GET_DONE;
         end
         ST_GET_DONE: begin
            rsp_load      = 1'b1;
            rsp_char_in   = byte_rd_ff;
            rsp_count_in  = blcq_pkg::COUNT_W'(fill_q_ff);
            state_in      = ST_ISSUE;
         end
         ST_PUT_DONE: begin
            if (need && free_head_ff == NULL_BLK) begin
               rsp_load      = 1'b1;
               rsp_status_in = blcq_pkg::STATUS_NO_BLOCK;
               rsp_count_in  = blcq_pkg::COUNT_W'(fill_q_ff);
            end else begin
               fill_we      = 1'b1;
               fill_wdata   = fill_q_ff + FW'(1);
               rsp_load     = 1'b1;
               rsp_count_in = blcq_pkg::COUNT_W'(fill_q_ff + FW'(1));
               byte_we      = 1'b1;
               end_we       = 1'b1;
               if (need) begin
                  // pop a block off the free list and chain it as the new tail
                  if (fresh) begin
                     fresh_cnt_in = free_head_ff;
                     free_head_in = (free_head_ff == '0) ? NULL_BLK :
                                    free_head_ff - BIW'(1);
                  end else begin
                     free_head_in = link_rd_ff;
                  end
                  start_we    = 1'b1;
                  start_waddr = free_head_ff[BAW-1:0];
                  start_wdata = '0;
                  end_waddr   = free_head_ff[BAW-1:0];
                  end_wdata   = OW'(1);
                  byte_waddr  = AW'(free_head_ff[BAW-1:0]) * AW'(BLOCK_BYTES);
                  tail_we     = 1'b1;
                  tail_wdata  = free_head_ff;
                  if (tail_q_ff != NULL_BLK) begin
                     link_we    = 1'b1;
                     link_waddr = tail_q_ff[BAW-1:0];
                     link_wdata = free_head_ff;
                  end else begin
                     head_we    = 1'b1;
                     head_wdata = free_head_ff;
                  end
               end
            end
            state_in = ST_ISSUE;
         end
         default: begin
            state_in = ST_ISSUE;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ISSUE;
         free_head_ff <= BIW'(NUM_BLOCKS - 1);
         fresh_cnt_ff <= BIW'(NUM_BLOCKS);
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < QN; i++) begin
            head_ff[i] <= NULL_BLK;
            tail_ff[i] <= NULL_BLK;
            fill_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         free_head_ff <= free_head_in;
         fresh_cnt_ff <= fresh_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (head_we) begin
            head_ff[q_cur] <= head_wdata;
         end
         if (tail_we) begin
            tail_ff[q_cur] <= tail_wdata;
         end
         if (fill_we) begin
            fill_ff[q_cur] <= fill_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      head_q_ff <= head_q_in;
      tail_q_ff <= tail_q_in;
      fill_q_ff <= fill_q_in;
      if (rsp_load) begin
         rsp_char_ff   <= rsp_char_in;
         rsp_status_ff <= rsp_status_in;
         rsp_count_ff  <= rsp_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
      link_rd_ff <= link_mem[link_raddr];
   end

   always_ff @(posedge clock) begin
      if (start_we) begin
         start_mem[start_waddr] <= start_wdata;
      end
      start_rd_ff <= start_mem[start_raddr];
   end

   always_ff @(posedge clock) begin
      if (end_we) begin
         end_mem[end_waddr] <= end_wdata;
      end
      end_rd_ff <= end_mem[end_raddr];
   end

   always_ff @(posedge clock) begin
      if (byte_we) begin
         byte_mem[byte_waddr] <= byte_wdata;
      end
      byte_rd_ff <= byte_mem[byte_raddr];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_char_out    = rsp_char_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_queue_count = rsp_count_ff;

endmodule

// ----- sv/block_linked_char_queues.sv -----
// top level of the block-linked character queues: csr register, intake and engine
// Byte FIFOs built from linked blocks of a shared pool, with a LIFO free list. Each
// transaction is put into a two-entry command queue and then executed by the engine:
// a get goes through the queue table and block offset reads, then the byte memory read,
// then the result; a put goes through the tail block fill and free-list link read, then
// the update; and a get on an empty queue or a request to an absent queue is answered
// at issue. The chain of dependent reads through the block offset memories and the byte
// memory sets these steps. A new transaction starts only while the result register is
// free or being drained. Blocks never yet handed out are tracked by a counter, so the
// pool needs no clearing pass after reset. The user must write block_size through
// csr_wr_en and csr_wr_data only while the block is idle; the block itself does not
// enforce this. Zero acts as one and values above the block capacity saturate.
module block_linked_char_queues #(
   parameter int NUM_BLOCKS  = 32,
   parameter int BLOCK_BYTES = 32,
   parameter int NUM_QUEUES  = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_type,
   input  logic [blcq_pkg::QID_W-1:0]    req_queue_id,
   input  logic [blcq_pkg::CHAR_W-1:0]   req_char_in,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [blcq_pkg::CHAR_W-1:0]   rsp_char_out,
   output logic [blcq_pkg::STATUS_W-1:0] rsp_status,
   output logic [blcq_pkg::COUNT_W-1:0]  rsp_queue_count,
   input  logic                          csr_wr_en,
   input  logic [blcq_pkg::BSIZE_W-1:0]  csr_wr_data
);

   logic [blcq_pkg::BSIZE_W-1:0] block_size_ff;
   logic                         cmd_valid;
   logic                         cmd_pop;
   blcq_pkg::cmd_type            cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         block_size_ff <= blcq_pkg::BSIZE_RESET;
      end else if (csr_wr_en) begin
         block_size_ff <= csr_wr_data;
      end
   end

   blcq_front #(
      .NUM_QUEUES (NUM_QUEUES)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_type     (req_type),
      .req_queue_id (req_queue_id),
      .req_char_in  (req_char_in),
      .cmd_valid    (cmd_valid),
      .cmd_pop      (cmd_pop),
      .cmd          (cmd)
   );

   blcq_back #(
      .NUM_BLOCKS  (NUM_BLOCKS),
      .BLOCK_BYTES (BLOCK_BYTES),
      .NUM_QUEUES  (NUM_QUEUES)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_valid       (cmd_valid),
      .cmd_pop         (cmd_pop),
      .cmd             (cmd),
      .block_size      (block_size_ff),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_char_out    (rsp_char_out),
      .rsp_status      (rsp_status),
      .rsp_queue_count (rsp_queue_count)
   );

`ifndef SYNTHESIS
   a_pop_needs_cmd: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid)
      else $error("command popped from an empty command queue");

   a_pop_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> (!rsp_valid || rsp_ready))
      else $error("transaction started while a result is still pending");

   a_empty_rsp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == blcq_pkg::STATUS_EMPTY) |->
      (rsp_queue_count == '0 && rsp_char_out == '0))
      else $error("empty result carries data or a count");
`endif

endmodule

// ----- tb/sv/block_linked_char_queues_tb.sv -----
// self-checking testbench for the block-linked character queues
module block_linked_char_queues_tb;

   localparam int NBLK        = 32;
   localparam int BBYTES      = 32;
   localparam int NQ          = 16;
   localparam int NULL_BLK    = NBLK;
   localparam int RAND_ITEMS  = 700;
   localparam int CYCLE_LIMIT = 200000;

   typedef struct packed {
      logic                        kind;
      logic [blcq_pkg::QID_W-1:0]  qid;
      logic [blcq_pkg::CHAR_W-1:0] ch;
   } char_req_type;

   typedef struct packed {
      logic [blcq_pkg::CHAR_W-1:0]   ch;
      logic [blcq_pkg::STATUS_W-1:0] status;
      logic [blcq_pkg::COUNT_W-1:0]  count;
   } char_rsp_type;

   logic                          clock           = 1'b0;
   logic                          reset           = 1'b1;
   logic                          req_valid       = 1'b0;
   logic                          req_ready;
   logic                          req_type        = blcq_pkg::REQ_PUT;
   logic [blcq_pkg::QID_W-1:0]    req_queue_id    = '0;
   logic [blcq_pkg::CHAR_W-1:0]   req_char_in     = '0;
   logic                          rsp_valid;
   logic                          rsp_ready       = 1'b0;
   logic [blcq_pkg::CHAR_W-1:0]   rsp_char_out;
   logic [blcq_pkg::STATUS_W-1:0] rsp_status;
   logic [blcq_pkg::COUNT_W-1:0]  rsp_queue_count;
   logic                          csr_wr_en       = 1'b0;
   logic [blcq_pkg::BSIZE_W-1:0]  csr_wr_data     = '0;

   block_linked_char_queues i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_queue_id    (req_queue_id),
      .req_char_in     (req_char_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_char_out    (rsp_char_out),
      .rsp_status      (rsp_status),
      .rsp_queue_count (rsp_queue_count),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // predicted pool and queue state
   logic [blcq_pkg::BSIZE_W-1:0] bsize_reg;
   logic [5:0]                   free_top;
   logic [5:0]                   link_tab [NBLK];
   logic [5:0]                   rd_off   [NBLK];
   logic [5:0]                   wr_off   [NBLK];
   logic [blcq_pkg::CHAR_W-1:0]  byte_mem [NBLK*BBYTES];
   logic [5:0]                   q_head   [NQ];
   logic [5:0]                   q_tail   [NQ];
   logic [blcq_pkg::COUNT_W-1:0] q_fill   [NQ];

   char_req_type pending_reqs [$];
   char_rsp_type expected_rsps [$];
   char_rsp_type want_rsp;
   char_req_type drv_item;

   logic req_fire = 1'b0;
   logic rsp_fire = 1'b0;
   int   req_hold = 0;
   int   rsp_hold = 0;
   bit   req_calm = 1'b0;
   bit   rsp_calm = 1'b0;
   int   err_count = 0;
   int   cycle_count = 0;

   task automatic reset_char_model();
      for (int i = 0; i < NBLK; i++) begin
         link_tab[i] = (i == 0) ? 6'(NULL_BLK) : 6'(i - 1);
         rd_off[i]   = '0;
         wr_off[i]   = '0;
      end
      for (int i = 0; i < NBLK*BBYTES; i++)
         byte_mem[i] = '0;
      for (int i = 0; i < NQ; i++) begin
         q_head[i] = 6'(NULL_BLK);
         q_tail[i] = 6'(NULL_BLK);
         q_fill[i] = '0;
      end
      free_top  = 6'(NBLK - 1);
      bsize_reg = blcq_pkg::BSIZE_RESET;
   endtask

   function automatic char_rsp_type predict_char_op(input char_req_type r);
      char_rsp_type res;
      int q, h, s, t, e, nb, lim;
      bit need;
      res = '0;
      q = r.qid;
      if (q >= NQ) begin
         // absent queue: nothing changes
         res.status = (r.kind == blcq_pkg::REQ_GET) ? blcq_pkg::STATUS_EMPTY :
                      blcq_pkg::STATUS_NO_BLOCK;
      end else if (r.kind == blcq_pkg::REQ_GET) begin
         h = q_head[q];
         if (q_fill[q] == 0 || h >= NBLK) begin
            res.status = blcq_pkg::STATUS_EMPTY;
         end else begin
            s = rd_off[h];
            res.ch = (s < BBYTES) ? byte_mem[h*BBYTES + s] : '0;
            s = s + 1;
            rd_off[h] = 6'(s);
            // drained head block goes back on top of the free list
            if (s >= wr_off[h]) begin
               if (link_tab[h] >= NBLK) begin
                  q_head[q] = 6'(NULL_BLK);
                  q_tail[q] = 6'(NULL_BLK);
               end else begin
                  q_head[q] = link_tab[h];
               end
               link_tab[h] = free_top;
               free_top = 6'(h);
            end
            q_fill[q] = q_fill[q] - blcq_pkg::COUNT_W'(1);
            res.status = blcq_pkg::STATUS_OK;
            res.count = q_fill[q];
         end
      end else begin
         lim = (bsize_reg == 0) ? 1 : ((bsize_reg > BBYTES) ? BBYTES : int'(bsize_reg));
         t = q_tail[q];
         need = (t >= NBLK) || (wr_off[t] >= lim);
         if (need && free_top >= NBLK) begin
            res.status = blcq_pkg::STATUS_NO_BLOCK;
            res.count = q_fill[q];
         end else begin
            if (need) begin
               nb = free_top;
               free_top = link_tab[nb];
               link_tab[nb] = 6'(NULL_BLK);
               rd_off[nb] = '0;
               wr_off[nb] = '0;
               if (t < NBLK)
                  link_tab[t] = 6'(nb);
               else
                  q_head[q] = 6'(nb);
               q_tail[q] = 6'(nb);
               t = nb;
            end
            e = wr_off[t];
            if (e < BBYTES)
               byte_mem[t*BBYTES + e] = r.ch;
            wr_off[t] = 6'(e + 1);
            q_fill[q] = q_fill[q] + blcq_pkg::COUNT_W'(1);
            res.status = blcq_pkg::STATUS_OK;
            res.count = q_fill[q];
         end
      end
      return res;
   endfunction

   function automatic int draw_wait(input bit calm);
      return calm ? 0 : int'($urandom_range(0, 17));
   endfunction

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_hold = 0;
      end else if (!req_valid || req_fire) begin
         if (req_hold > 0) begin
            req_valid <= 1'b0;
            req_hold = req_hold - 1;
         end else if (pending_reqs.size() != 0) begin
            drv_item = pending_reqs.pop_front();
            req_valid    <= 1'b1;
            req_type     <= drv_item.kind;
            req_queue_id <= drv_item.qid;
            req_char_in  <= drv_item.ch;
            if ($urandom_range(0, 39) == 0)
               req_calm = !req_calm;
            req_hold = draw_wait(req_calm);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response side back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_fire) begin
            if ($urandom_range(0, 39) == 0)
               rsp_calm = !rsp_calm;
            rsp_hold = draw_wait(rsp_calm);
         end
         if (rsp_hold > 0) begin
            rsp_ready <= 1'b0;
            rsp_hold = rsp_hold - 1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // monitor: check the response first, then record the request of this edge
   always @(posedge clock) begin
      req_fire <= !reset && req_valid && req_ready;
      rsp_fire <= !reset && rsp_valid && rsp_ready;
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL block_linked_char_queues");
         $finish;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            $error("response transaction with no request outstanding");
            err_count = err_count + 1;
         end else begin
            want_rsp = expected_rsps.pop_front();
            if (rsp_char_out !== want_rsp.ch) begin
               $error("char_out: expected %0h, actual %0h", want_rsp.ch, rsp_char_out);
               err_count = err_count + 1;
            end
            if (rsp_status !== want_rsp.status) begin
               $error("status: expected %0d, actual %0d", want_rsp.status, rsp_status);
               err_count = err_count + 1;
            end
            if (rsp_queue_count !== want_rsp.count) begin
               $error("queue_count: expected %0d, actual %0d",
                      want_rsp.count, rsp_queue_count);
               err_count = err_count + 1;
            end
         end
      end
      if (!reset && req_valid && req_ready)
         expected_rsps.push_back(predict_char_op({req_type, req_queue_id, req_char_in}));
   end

   task automatic push_req(input logic kind, input int qid, input int ch);
      char_req_type r;
      r.kind = kind;
      r.qid  = blcq_pkg::QID_W'(qid);
      r.ch   = blcq_pkg::CHAR_W'(ch);
      pending_reqs.push_back(r);
   endtask

   task automatic wait_drained();
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
         @(posedge clock);
   endtask

   // only called with nothing in flight
   task automatic write_block_size(input int v);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= blcq_pkg::BSIZE_W'(v);
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      bsize_reg = blcq_pkg::BSIZE_W'(v);
   endtask

   initial begin
      int rand_done, phase_no, n, put_pct, span, base, bs;
      reset_char_model();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // basic put/get order, empty gets, extreme bytes and queue numbers
      push_req(blcq_pkg::REQ_PUT, 0, 8'h00);
      push_req(blcq_pkg::REQ_PUT, 0, 8'hFF);
      push_req(blcq_pkg::REQ_PUT, 15, 8'hA5);
      push_req(blcq_pkg::REQ_GET, 0, 8'h00);
      push_req(blcq_pkg::REQ_GET, 0, 8'h00);
      push_req(blcq_pkg::REQ_GET, 0, 8'h00);
      push_req(blcq_pkg::REQ_GET, 15, 8'h00);
      push_req(blcq_pkg::REQ_GET, 15, 8'hFF);
      push_req(blcq_pkg::REQ_PUT, 3, 8'h55);
      push_req(blcq_pkg::REQ_PUT, 3, 8'hAA);
      push_req(blcq_pkg::REQ_PUT, 3, 8'h0F);
      wait_drained();
      // size lowered below the current tail fill: next put chains a new block
      write_block_size(2);
      push_req(blcq_pkg::REQ_PUT, 3, 8'hF0);
      repeat (4) push_req(blcq_pkg::REQ_GET, 3, 8'h00);
      wait_drained();
      // zero acts as one byte per block
      write_block_size(0);
      push_req(blcq_pkg::REQ_PUT, 8, 8'h11);
      push_req(blcq_pkg::REQ_PUT, 8, 8'h22);
      push_req(blcq_pkg::REQ_GET, 8, 8'h00);
      push_req(blcq_pkg::REQ_GET, 8, 8'h00);
      wait_drained();
      // above capacity saturates
      write_block_size(63);
      push_req(blcq_pkg::REQ_PUT, 12, 8'h80);
      push_req(blcq_pkg::REQ_GET, 12, 8'h00);
      wait_drained();

      rand_done = 0;
      phase_no  = 0;
      while (rand_done < RAND_ITEMS) begin
         case (phase_no)
            0: bs = 1;
            1: bs = 63;
            2: bs = 0;
            3: bs = 32;
            4: bs = 2;
            default: bs = $urandom_range(0, 1) ? $urandom_range(1, 4) : $urandom_range(0, 63);
         endcase
         write_block_size(bs);
         n = $urandom_range(30, 70);
         // first phase is put-heavy so the pool runs dry
         put_pct = (phase_no == 0) ? 90 : $urandom_range(15, 85);
         span = 1 << $urandom_range(0, 4);
         base = $urandom_range(0, 15);
         for (int i = 0; i < n; i++)
            push_req(($urandom_range(0, 99) < put_pct) ? blcq_pkg::REQ_PUT : blcq_pkg::REQ_GET,
                     (base + $urandom_range(0, span - 1)) % NQ, $urandom_range(0, 255));
         wait_drained();
         rand_done = rand_done + n;
         phase_no  = phase_no + 1;
      end

      repeat (20) @(posedge clock);
      if (err_count == 0)
         $display("PASS block_linked_char_queues");
      else
         $display("FAIL block_linked_char_queues");
      $finish;
   end

endmodule
